FILE: rtl/aesdm_pkg.sv
// ----------------------------------------------------------------------------
// aesdm_pkg: shared types and functions of the Davies-Meyer hash core
// Request codes, the AES S-box and the GF(2^8) helpers.
// ----------------------------------------------------------------------------
package aesdm_pkg;

  typedef enum logic [1:0] {
    REQ_ABSORB   = 2'd0,
    REQ_START    = 2'd1,
    REQ_FINALIZE = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  // Configuration register indexes.
  localparam logic CfgIvHigh = 1'b0;
  localparam logic CfgIvLow  = 1'b1;

  localparam int unsigned NumRounds = 10;
  localparam logic [7:0]  RconInit  = 8'h01;

  typedef struct packed {
    logic         start;
    logic [127:0] key;
    logic [127:0] data;
  } aes_cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] tab [256];
    tab = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tab[a];
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit word sits at bits [127-8i -: 8].
  function automatic logic [7:0] byte_at(input logic [127:0] w, input int i);
    return w[127 - 8*i -: 8];
  endfunction

endpackage

FILE: rtl/aesdm_stream_if.sv
// ----------------------------------------------------------------------------
// aesdm_stream_if: valid/ready channel with a payload
// One beat moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface aesdm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  modport source (output valid, req_type, data_byte, input ready);
  modport sink   (input valid, req_type, data_byte, output ready);
endinterface

interface aesdm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        is_last;
  modport source (output valid, digest_word, is_last, input ready);
  modport sink   (input valid, digest_word, is_last, output ready);
endinterface

FILE: rtl/aesdm_round_unit.sv
// ----------------------------------------------------------------------------
// aesdm_round_unit: iterative AES-128 encryption
// One round and one key expansion step per cycle.
// ----------------------------------------------------------------------------
module aesdm_round_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  aesdm_pkg::aes_cmd_t cmd,
  output logic                done,
  output logic [127:0]        result
);

  logic [127:0] st_r, st_nxt, rk_r, rk_nxt;
  logic [7:0]   rcon_r, rcon_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic         busy_r, busy_nxt;
  logic [127:0] rk_next, sub_shift, mixed;

  always_comb begin
    logic [7:0] t [4];
    logic [7:0] a0, a1, a2, a3, all;
    t[0] = aesdm_pkg::sbox(aesdm_pkg::byte_at(rk_r, 13)) ^ rcon_r;
    t[1] = aesdm_pkg::sbox(aesdm_pkg::byte_at(rk_r, 14));
    t[2] = aesdm_pkg::sbox(aesdm_pkg::byte_at(rk_r, 15));
    t[3] = aesdm_pkg::sbox(aesdm_pkg::byte_at(rk_r, 12));
    for (int i = 0; i < 4; i++) begin
      rk_next[127-8*i -: 8] = aesdm_pkg::byte_at(rk_r, i) ^ t[i];
    end
    for (int i = 4; i < 16; i++) begin
      rk_next[127-8*i -: 8] = aesdm_pkg::byte_at(rk_r, i) ^ rk_next[127-8*(i-4) -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sub_shift[127-8*(4*c+r) -: 8] =
          aesdm_pkg::sbox(aesdm_pkg::byte_at(st_r, 4*((c+r)%4)+r));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = aesdm_pkg::byte_at(sub_shift, 4*c);
      a1 = aesdm_pkg::byte_at(sub_shift, 4*c+1);
      a2 = aesdm_pkg::byte_at(sub_shift, 4*c+2);
      a3 = aesdm_pkg::byte_at(sub_shift, 4*c+3);
      all = a0 ^ a1 ^ a2 ^ a3;
      mixed[127-8*(4*c)   -: 8] = a0 ^ all ^ aesdm_pkg::gf_double(a0 ^ a1);
      mixed[127-8*(4*c+1) -: 8] = a1 ^ all ^ aesdm_pkg::gf_double(a1 ^ a2);
      mixed[127-8*(4*c+2) -: 8] = a2 ^ all ^ aesdm_pkg::gf_double(a2 ^ a3);
      mixed[127-8*(4*c+3) -: 8] = a3 ^ all ^ aesdm_pkg::gf_double(a3 ^ a0);
    end
  end

  always_comb begin
    st_nxt   = st_r;
    rk_nxt   = rk_r;
    rcon_nxt = rcon_r;
    rnd_nxt  = rnd_r;
    busy_nxt = busy_r;
    if (cmd.start) begin
      st_nxt   = cmd.data ^ cmd.key;
      rk_nxt   = cmd.key;
      rcon_nxt = aesdm_pkg::RconInit;
      rnd_nxt  = 4'd1;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rk_nxt   = rk_next;
      rcon_nxt = aesdm_pkg::gf_double(rcon_r);
      st_nxt   = ((rnd_r == 4'(aesdm_pkg::NumRounds)) ? sub_shift : mixed) ^ rk_next;
      rnd_nxt  = rnd_r + 4'd1;
      if (rnd_r == 4'(aesdm_pkg::NumRounds)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      rnd_r  <= rnd_nxt;
    end
    st_r   <= st_nxt;
    rk_r   <= rk_nxt;
    rcon_r <= rcon_nxt;
  end

  // done pulses for one cycle after the last round has been stored.
  logic done_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && !cmd.start && (rnd_r == 4'(aesdm_pkg::NumRounds));
    end
  end

  assign done   = done_r;
  assign result = st_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(busy_r)) else $error("done without a running block");
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rnd_r >= 4'd1 && rnd_r <= 4'(aesdm_pkg::NumRounds)))
    else $error("round counter out of range");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !busy_r) else $error("done while still busy");

endmodule

FILE: rtl/aes128_davies_meyer_hash_core.sv
// ----------------------------------------------------------------------------
// aes128_davies_meyer_hash_core: Davies-Meyer hash over AES-128
// Byte-serial absorb, start from IV, finalize to a two-word digest.
// ----------------------------------------------------------------------------
// Usage: each input beat carries req_type and data_byte. An absorb beat
// stores one byte; the sixteenth byte of a block runs a compression. A start
// beat loads the chaining value from iv_high/iv_low and empties the buffer.
// A finalize beat zero-pads a partial block, compresses it if it holds any
// byte, and sends two output beats: chaining bytes 0..7, then bytes 8..15
// with is_last set. Request code 3 is dropped.
// Timing: absorb and start beats are taken while idle. A compression runs
// in the AES round unit, one round per cycle, with in_ready low until done.
// A finalize then holds the input until both digest beats have been taken;
// each digest beat waits as long as out_ready stays low. Configuration writes
// go through cfg_* and must come only while idle, a rule left to the user.
// Reset clears the chaining value, the IV registers and the fill count.
// ----------------------------------------------------------------------------
module aes128_davies_meyer_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata,
  aesdm_in_if.sink    in_ch,
  aesdm_out_if.source out_ch
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_WAIT  = 5'b00100,
    ST_OUT0  = 5'b01000,
    ST_OUT1  = 5'b10000
  } state_t;

  state_t       state_r, state_nxt;
  logic [63:0]  iv_high_r, iv_low_r;
  logic [127:0] chain_r, chain_nxt;
  logic [127:0] buf_r, buf_nxt;
  logic [3:0]   fill_r, fill_nxt;
  logic         fin_r, fin_nxt;
  logic         in_acc;
  aesdm_pkg::aes_cmd_t cmd;
  logic         aes_done;
  logic [127:0] aes_result;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_high_r <= '0;
      iv_low_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == aesdm_pkg::CfgIvLow) iv_low_r <= cfg_wdata;
      else                                  iv_high_r <= cfg_wdata;
    end
  end

  always_comb begin
    state_nxt = state_r;
    chain_nxt = chain_r;
    buf_nxt   = buf_r;
    fill_nxt  = fill_r;
    fin_nxt   = fin_r;
    cmd.start = 1'b0;
    cmd.key   = buf_r;
    cmd.data  = chain_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (aesdm_pkg::req_t'(in_ch.req_type))
            aesdm_pkg::REQ_ABSORB: begin
              buf_nxt[127 - 8*fill_r -: 8] = in_ch.data_byte;
              fill_nxt = fill_r + 4'd1;
              if (fill_r == 4'd15) begin
                fin_nxt   = 1'b0;
                state_nxt = ST_LOAD;
              end
            end
            aesdm_pkg::REQ_START: begin
              chain_nxt = {iv_high_r, iv_low_r};
              buf_nxt   = '0;
              fill_nxt  = '0;
            end
            aesdm_pkg::REQ_FINALIZE: begin
              fin_nxt = 1'b1;
              if (fill_r != 4'd0) begin
                // Zero padding above the fill point.
                for (int k = 0; k < 16; k++) begin
                  if (4'(k) >= fill_r) buf_nxt[127 - 8*k -: 8] = 8'h00;
                end
                fill_nxt  = '0;
                state_nxt = ST_LOAD;
              end else begin
                state_nxt = ST_OUT0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.start = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (aes_done) begin
          chain_nxt = aes_result ^ chain_r;
          state_nxt = fin_r ? ST_OUT0 : ST_IDLE;
        end
      end
      ST_OUT0: if (out_ch.ready) state_nxt = ST_OUT1;
      ST_OUT1: if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      chain_r <= '0;
      fill_r  <= '0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chain_r <= chain_nxt;
      fill_r  <= fill_nxt;
      fin_r   <= fin_nxt;
    end
    buf_r <= buf_nxt;
  end

  aesdm_round_unit u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .done   (aes_done),
    .result (aes_result)
  );

  assign out_ch.valid       = (state_r == ST_OUT0) || (state_r == ST_OUT1);
  assign out_ch.is_last     = (state_r == ST_OUT1);
  assign out_ch.digest_word = (state_r == ST_OUT1) ? chain_r[63:0] : chain_r[127:64];

  a_chain_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT0) |=> $stable(chain_r)) else $error("chain changed during output");
  a_fill_zero_comp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT) |-> (fill_r == 4'd0)) else $error("fill count not cleared");
  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT0 && out_ch.ready) |=> (state_r == ST_OUT1))
    else $error("second digest beat missing");

endmodule

FILE: tb/tb_aes128_davies_meyer_hash_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aes128_davies_meyer_hash_core: self-checking bench for the hash core
// Feeds absorb, start, finalize and unused request beats with bursty
// timing. It also stalls the digest channel. Each digest beat is checked
// against a local AES-128 Davies-Meyer predictor. The run steps through
// several IV settings.
// ----------------------------------------------------------------------------
module tb_aes128_davies_meyer_hash_core;

  localparam int   RandomItems  = 1550;
  localparam int   SettleCycles = 40;
  localparam int   CycleLimit   = 400000;

  typedef struct packed {
    aesdm_pkg::req_t req;
    logic [7:0]      data;
  } req_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [63:0] cfg_wdata = '0;

  aesdm_in_if  in_if ();
  aesdm_out_if out_if ();

  aes128_davies_meyer_hash_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  always #2 clk = ~clk;

  // Predictor state.
  logic [7:0]  sub_tab [256];
  logic [63:0] iv_hi_m = '0, iv_lo_m = '0;
  logic [63:0] chain_hi = '0, chain_lo = '0;
  logic [7:0]  msg_block [16];
  int          fill_m = 0;

  req_beat_t   pending_beats [$];
  logic [63:0] digest_q [$];
  logic        last_q [$];
  bit          failed = 1'b0;
  bit          in_taken = 1'b0;
  int          burst_left = 0, gap_left = 0;
  int          cycle_cnt = 0;

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= x;
      x = xtime(x);
    end
    return p;
  endfunction

  // S-box from the field inverse (a^254) followed by the affine map.
  function automatic logic [7:0] build_sub(input logic [7:0] a);
    logic [7:0] inv;
    inv = 8'h01;
    for (int i = 0; i < 254; i++) inv = gmul(inv, a);
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
         ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] pt, input logic [127:0] key);
    logic [7:0] st [16];
    logic [7:0] rk [16];
    logic [7:0] tmp [16];
    logic [7:0] rc, t0, t1, t2, t3, a0, a1, a2, a3, al;
    logic [127:0] ct;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127 - 8*i -: 8];
      st[i] = pt[127 - 8*i -: 8] ^ rk[i];
    end
    for (int rnd = 1; rnd <= 10; rnd++) begin
      t0 = sub_tab[rk[13]] ^ rc;
      t1 = sub_tab[rk[14]];
      t2 = sub_tab[rk[15]];
      t3 = sub_tab[rk[12]];
      rk[0] ^= t0; rk[1] ^= t1; rk[2] ^= t2; rk[3] ^= t3;
      for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
      rc = xtime(rc);
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          tmp[4*c + r] = sub_tab[st[4*((c + r) % 4) + r]];
      for (int c = 0; c < 4; c++) begin
        if (rnd < 10) begin
          a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
          st[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
          st[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
          st[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
        end else begin
          for (int r = 0; r < 4; r++) st[4*c + r] = tmp[4*c + r];
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    end
    for (int i = 0; i < 16; i++) ct[127 - 8*i -: 8] = st[i];
    return ct;
  endfunction

  task automatic compress_chain();
    logic [127:0] prev, key;
    prev = {chain_hi, chain_lo};
    for (int i = 0; i < 16; i++) key[127 - 8*i -: 8] = msg_block[i];
    {chain_hi, chain_lo} = aes_encrypt(prev, key) ^ prev;
  endtask

  task automatic hash_step(input aesdm_pkg::req_t req, input logic [7:0] data);
    case (req)
      aesdm_pkg::REQ_ABSORB: begin
        msg_block[fill_m] = data;
        fill_m++;
        if (fill_m == 16) begin
          compress_chain();
          fill_m = 0;
        end
      end
      aesdm_pkg::REQ_START: begin
        chain_hi = iv_hi_m;
        chain_lo = iv_lo_m;
        for (int i = 0; i < 16; i++) msg_block[i] = 8'h00;
        fill_m = 0;
      end
      aesdm_pkg::REQ_FINALIZE: begin
        if (fill_m > 0) begin
          for (int k = fill_m; k < 16; k++) msg_block[k] = 8'h00;
          compress_chain();
          fill_m = 0;
        end
        digest_q.push_back(chain_hi); last_q.push_back(1'b0);
        digest_q.push_back(chain_lo); last_q.push_back(1'b1);
      end
      default: ;
    endcase
  endtask

  // Input driver: bursts of beats with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        req_beat_t b;
        b = pending_beats.pop_front();
        in_if.valid     <= 1'b1;
        in_if.req_type  <= b.req;
        in_if.data_byte <= b.data;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Digest receiver: free-flowing, random and long-stall stretches.
  always @(negedge clk) begin
    case ((cycle_cnt / 300) % 3)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= ($urandom_range(0, 1) == 1);
      default: out_if.ready <= ((cycle_cnt % 23) < 2);
    endcase
  end

  // Monitor: predict on each accepted request, check each digest beat.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    in_taken <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready)
      hash_step(aesdm_pkg::req_t'(in_if.req_type), in_if.data_byte);
    if (rst_n && out_if.valid && out_if.ready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest beat %h last %b", $time,
                 out_if.digest_word, out_if.is_last);
        failed = 1'b1;
      end else begin
        if (out_if.digest_word !== digest_q[0] || out_if.is_last !== last_q[0]) begin
          $display("%0t: digest mismatch expected %h last %b, actual %h last %b", $time,
                   digest_q[0], last_q[0], out_if.digest_word, out_if.is_last);
          failed = 1'b1;
        end
        void'(digest_q.pop_front());
        void'(last_q.pop_front());
      end
    end
    if (cycle_cnt > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_beat(input aesdm_pkg::req_t req, input logic [7:0] data);
    pending_beats.push_back('{req: req, data: data});
  endtask

  task automatic write_iv(input logic [63:0] hi, input logic [63:0] lo);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= aesdm_pkg::CfgIvHigh; cfg_wdata <= hi;
    @(posedge clk);
    iv_hi_m = hi;
    @(negedge clk);
    cfg_index <= aesdm_pkg::CfgIvLow; cfg_wdata <= lo;
    @(posedge clk);
    iv_lo_m = lo;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every request has gone in and every digest beat has come out;
  // a trailing compression gives no beat, so allow it time to finish.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_beats.size() > 0 || in_if.valid || digest_q.size() > 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Mostly well-formed messages with random content, some noise mixed in.
  task automatic add_random_messages(input int count);
    int n, len;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 3) != 0) begin
        push_beat(aesdm_pkg::REQ_START, 8'($urandom));
        n++;
      end
      len = ($urandom_range(0, 4) == 0) ? 16 * $urandom_range(0, 3) : $urandom_range(0, 40);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 30) == 0) push_beat(aesdm_pkg::REQ_NONE, 8'($urandom));
        push_beat(aesdm_pkg::REQ_ABSORB, 8'($urandom));
      end
      push_beat(aesdm_pkg::REQ_FINALIZE, 8'($urandom));
      n += len + 1;
    end
  endtask

  initial begin
    for (int i = 0; i < 256; i++) sub_tab[i] = build_sub(8'(i));
    for (int i = 0; i < 16; i++) msg_block[i] = 8'h00;
    in_if.valid = 1'b0;
    in_if.req_type = aesdm_pkg::REQ_NONE;
    in_if.data_byte = 8'h00;
    out_if.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: finalize straight after reset, a full block opening with extreme
    // bytes, an empty finalize, an unused request code, then a partial block.
    write_iv(64'h0, 64'h0);
    push_beat(aesdm_pkg::REQ_FINALIZE, 8'h00);
    push_beat(aesdm_pkg::REQ_START, 8'hff);
    for (int i = 0; i < 16; i++)
      push_beat(aesdm_pkg::REQ_ABSORB,
                (i < 4) ? ((i % 2) ? 8'hff : 8'h00) : 8'($urandom));
    push_beat(aesdm_pkg::REQ_FINALIZE, 8'hff);
    push_beat(aesdm_pkg::REQ_NONE, 8'h5a);
    push_beat(aesdm_pkg::REQ_ABSORB, 8'h80);
    push_beat(aesdm_pkg::REQ_ABSORB, 8'h7f);
    push_beat(aesdm_pkg::REQ_FINALIZE, 8'h00);
    wait_drained();

    write_iv(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    add_random_messages(RandomItems / 4);
    wait_drained();

    write_iv({$urandom, $urandom}, {$urandom, $urandom});
    add_random_messages(RandomItems / 4);
    wait_drained();

    write_iv(64'hffff_ffff_ffff_ffff, 64'h0);
    add_random_messages(RandomItems / 4);
    wait_drained();

    write_iv({$urandom, $urandom}, {$urandom, $urandom});
    add_random_messages(RandomItems / 4);
    wait_drained();

    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
